/* rtl/srb_pkg.sv */
// srb_pkg: shared types, constants and controller/datapath interface structs
// for the shape rasterizer bitmap block
// no dependencies
package srb_pkg;

    // default canvas size
    localparam int DEF_CANVAS_WIDTH  = 80;
    localparam int DEF_CANVAS_HEIGHT = 25;

    // item field widths
    localparam int FUNC_W = 3;
    localparam int XF_W   = 7;
    localparam int YF_W   = 5;

    // internal signed coordinate width, covers -127 .. 254 plus margin
    localparam int COORD_W = 10;
    // bresenham error term width
    localparam int LERR_W  = 12;
    // circle decision variable width
    localparam int CD_W    = 14;

    // circle decision constants
    localparam int CIRC_D_INIT = 3;
    localparam int CIRC_D_DIAG = 10;
    localparam int CIRC_D_AXIS = 6;

    typedef enum logic [FUNC_W-1:0] {
        F_CLEAR = 3'd0,
        F_LINE  = 3'd1,
        F_RECT  = 3'd2,
        F_CIRC  = 3'd3,
        F_TRI   = 3'd4,
        F_READ  = 3'd5
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [XF_W-1:0]   x_a;
        logic [YF_W-1:0]   y_a;
        logic [XF_W-1:0]   x_b;
        logic [YF_W-1:0]   y_b;
        logic [XF_W-1:0]   x_c;
        logic [YF_W-1:0]   y_c;
        logic [XF_W-1:0]   rect_w;
        logic [YF_W-1:0]   rect_h;
        logic [XF_W-1:0]   radius;
    } t_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic res_clear;
        logic res_capture;
        logic line_load;
        logic line_step;
        logic seg_next;
        logic circ_init;
        logic circ_step;
        logic oct_next;
        logic use_circ;
        logic mem_rd;
        logic mem_wr;
        logic mem_clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic rect_nonzero;
        logic line_end;
        logic seg_last;
        logic r_zero;
        logic oct_last;
        logic circ_more;
        logic pixel;
    } t_status;

endpackage

/* rtl/srb_canvas.sv */
// srb_canvas: one-bit canvas stored as one memory word per row, with
// per-row valid bits so that a clear only resets the valid bits, with no sweep
// depends on srb_pkg
module srb_canvas
    import srb_pkg::*;
#(
    parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT,
    localparam int COL_W = $clog2(CANVAS_WIDTH),
    localparam int ROW_W = $clog2(CANVAS_HEIGHT)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd,
    input  logic             i_wr,
    input  logic             i_clear,
    input  logic [ROW_W-1:0] i_row,
    input  logic [COL_W-1:0] i_col,
    output logic             o_pixel
);

    logic [CANVAS_WIDTH-1:0]  mem [CANVAS_HEIGHT];
    logic [CANVAS_HEIGHT-1:0] r_row_vld;
    logic [CANVAS_WIDTH-1:0]  r_rd_row;
    logic                     r_rd_vld;
    logic [CANVAS_WIDTH-1:0]  row_q;

    // row as last read, background where the row was never written
    assign row_q   = r_rd_vld ? r_rd_row : '0;
    assign o_pixel = row_q[i_col];

    // row memory, registered read, read-modify-write sets one bit
    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_rd_row <= mem[i_row];
        end
        if (i_wr) begin
            mem[i_row] <= row_q | (CANVAS_WIDTH'(1) << i_col);
        end
    end

    // row valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr) begin
                r_row_vld[i_row] <= 1'b1;
            end
            if (i_rd) begin
                r_rd_vld <= r_row_vld[i_row];
            end
        end
    end

endmodule

/* rtl/srb_datapath.sv */
// srb_datapath: item registers, bresenham line stepper, midpoint circle
// stepper, pixel address clipping and the canvas
// depends on srb_pkg, srb_canvas
module srb_datapath
    import srb_pkg::*;
#(
    parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_status o_status
);

    localparam int COL_W = $clog2(CANVAS_WIDTH);
    localparam int ROW_W = $clog2(CANVAS_HEIGHT);

    typedef logic signed [COORD_W-1:0] t_crd;

    t_item r_item;
    logic [1:0] r_seg;
    t_crd r_lx, r_ly, r_lx1, r_ly1;
    logic signed [LERR_W-1:0] r_err, r_dx, r_dy;
    logic r_sx_neg, r_sy_neg;
    t_crd r_cx, r_cy;
    logic [2:0] r_oct;
    logic signed [CD_W-1:0] r_d;
    logic r_pixel;

    t_crd ax, ay, bx, by, cx, cy, xr, yb;
    t_crd ex0, ey0, ex1, ey1;
    t_crd px, py;
    t_crd ldx, ldy;
    logic signed [LERR_W-1:0] e2;
    t_crd nx, ny;
    logic signed [CD_W-1:0] nd;
    logic on_canvas;
    logic canvas_pix;

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    // item coordinates as signed values
    assign ax = t_crd'(r_item.x_a);
    assign ay = t_crd'(r_item.y_a);
    assign bx = t_crd'(r_item.x_b);
    assign by = t_crd'(r_item.y_b);
    assign cx = t_crd'(r_item.x_c);
    assign cy = t_crd'(r_item.y_c);
    assign xr = ax + t_crd'(r_item.rect_w) - t_crd'(1);
    assign yb = ay + t_crd'(r_item.rect_h) - t_crd'(1);

    // segment endpoints by command and segment number
    always_comb begin
        ex0 = ax; ey0 = ay; ex1 = bx; ey1 = by;
        if (r_item.func == F_RECT) begin
            unique case (r_seg)
                2'd0: begin ex0 = ax; ey0 = ay; ex1 = xr; ey1 = ay; end
                2'd1: begin ex0 = ax; ey0 = yb; ex1 = xr; ey1 = yb; end
                2'd2: begin ex0 = ax; ey0 = ay; ex1 = ax; ey1 = yb; end
                default: begin ex0 = xr; ey0 = ay; ex1 = xr; ey1 = yb; end
            endcase
        end else if (r_item.func == F_TRI) begin
            unique case (r_seg)
                2'd0: begin ex0 = ax; ey0 = ay; ex1 = bx; ey1 = by; end
                2'd1: begin ex0 = bx; ey0 = by; ex1 = cx; ey1 = cy; end
                default: begin ex0 = cx; ey0 = cy; ex1 = ax; ey1 = ay; end
            endcase
        end
    end

    // segment counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_seg <= 2'd0;
        end else if (i_cmd.seg_next) begin
            r_seg <= r_seg + 2'd1;
        end
    end

    assign ldx = (ex1 > ex0) ? ex1 - ex0 : ex0 - ex1;
    assign ldy = (ey1 > ey0) ? ey1 - ey0 : ey0 - ey1;
    assign e2  = r_err <<< 1;

    // bresenham line stepper
    always_ff @(posedge i_clk) begin
        if (i_cmd.line_load) begin
            r_lx     <= ex0;
            r_ly     <= ey0;
            r_lx1    <= ex1;
            r_ly1    <= ey1;
            r_dx     <= LERR_W'(ldx);
            r_dy     <= LERR_W'(ldy);
            r_err    <= LERR_W'(ldx) - LERR_W'(ldy);
            r_sx_neg <= !(ex0 < ex1);
            r_sy_neg <= !(ey0 < ey1);
        end else if (i_cmd.line_step) begin
            if ((e2 > -r_dy) && (e2 < r_dx)) begin
                r_err <= r_err - r_dy + r_dx;
            end else if (e2 > -r_dy) begin
                r_err <= r_err - r_dy;
            end else if (e2 < r_dx) begin
                r_err <= r_err + r_dx;
            end
            if (e2 > -r_dy) begin
                r_lx <= r_sx_neg ? r_lx - t_crd'(1) : r_lx + t_crd'(1);
            end
            if (e2 < r_dx) begin
                r_ly <= r_sy_neg ? r_ly - t_crd'(1) : r_ly + t_crd'(1);
            end
        end
    end

    // next circle step values
    assign nx = r_cx + t_crd'(1);
    assign ny = r_cy - t_crd'(1);
    assign nd = (r_d > 0)
              ? r_d + (CD_W'(nx - ny) <<< 2) + CD_W'(CIRC_D_DIAG)
              : r_d + (CD_W'(nx) <<< 2) + CD_W'(CIRC_D_AXIS);

    // midpoint circle stepper, r_cx / r_cy are the offsets x and y
    always_ff @(posedge i_clk) begin
        if (i_cmd.circ_init) begin
            r_cx  <= '0;
            r_cy  <= t_crd'(r_item.radius);
            r_d   <= CD_W'(CIRC_D_INIT) - (CD_W'(r_item.radius) <<< 1);
            r_oct <= 3'd0;
        end else if (i_cmd.circ_step) begin
            r_cx  <= nx;
            if (r_d > 0) begin
                r_cy <= ny;
            end
            r_d   <= nd;
            r_oct <= 3'd0;
        end else if (i_cmd.oct_next) begin
            r_oct <= r_oct + 3'd1;
        end
    end

    // current plot point
    always_comb begin
        px = r_lx;
        py = r_ly;
        if (i_cmd.use_circ) begin
            unique case (r_oct)
                3'd0: begin px = ax + r_cx; py = ay + r_cy; end
                3'd1: begin px = ax - r_cx; py = ay + r_cy; end
                3'd2: begin px = ax + r_cx; py = ay - r_cy; end
                3'd3: begin px = ax - r_cx; py = ay - r_cy; end
                3'd4: begin px = ax + r_cy; py = ay + r_cx; end
                3'd5: begin px = ax - r_cy; py = ay + r_cx; end
                3'd6: begin px = ax + r_cy; py = ay - r_cx; end
                default: begin px = ax - r_cy; py = ay - r_cx; end
            endcase
        end
    end

    // clipping against the canvas
    assign on_canvas = (px >= 0) && (px < t_crd'(CANVAS_WIDTH))
                    && (py >= 0) && (py < t_crd'(CANVAS_HEIGHT));

    srb_canvas #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (i_cmd.mem_rd),
        .i_wr    (i_cmd.mem_wr && on_canvas),
        .i_clear (i_cmd.mem_clear),
        .i_row   (py[ROW_W-1:0]),
        .i_col   (px[COL_W-1:0]),
        .o_pixel (canvas_pix)
    );

    // read result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_clear) begin
            r_pixel <= 1'b0;
        end else if (i_cmd.res_capture) begin
            r_pixel <= on_canvas && canvas_pix;
        end
    end

    // status
    always_comb begin
        o_status.func         = r_item.func;
        o_status.rect_nonzero = (r_item.rect_w != '0) && (r_item.rect_h != '0);
        o_status.line_end     = (r_lx == r_lx1) && (r_ly == r_ly1);
        o_status.seg_last     = (r_item.func == F_RECT) ? (r_seg == 2'd3)
                              : (r_item.func == F_TRI)  ? (r_seg == 2'd2)
                              : 1'b1;
        o_status.r_zero       = (r_item.radius == '0);
        o_status.oct_last     = (r_oct == 3'd7);
        o_status.circ_more    = (r_cy >= r_cx);
        o_status.pixel        = r_pixel;
    end

endmodule

/* rtl/srb_ctrl.sv */
// srb_ctrl: command sequencer state machine and output register
// depends on srb_pkg
module srb_ctrl
    import srb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output logic    o_out_pixel,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DISP  = 12'b0000_0000_0010,
        S_LLOAD = 12'b0000_0000_0100,
        S_LRD   = 12'b0000_0000_1000,
        S_LWR   = 12'b0000_0001_0000,
        S_CINIT = 12'b0000_0010_0000,
        S_CRD   = 12'b0000_0100_0000,
        S_CWR   = 12'b0000_1000_0000,
        S_RLOAD = 12'b0001_0000_0000,
        S_RRD   = 12'b0010_0000_0000,
        S_RWT   = 12'b0100_0000_0000,
        S_FIN   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_out_pixel, n_out_pixel;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_pixel = r_out_pixel;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.res_clear = 1'b1;
                unique case (i_status.func)
                    F_CLEAR: begin
                        o_cmd.mem_clear = 1'b1;
                        n_state         = S_FIN;
                    end
                    F_LINE, F_TRI: n_state = S_LLOAD;
                    F_RECT:  n_state = i_status.rect_nonzero ? S_LLOAD : S_FIN;
                    F_CIRC:  n_state = S_CINIT;
                    F_READ:  n_state = S_RLOAD;
                    default: n_state = S_FIN;
                endcase
            end
            S_LLOAD: begin
                o_cmd.line_load = 1'b1;
                n_state         = S_LRD;
            end
            S_LRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_LWR;
            end
            S_LWR: begin
                o_cmd.mem_wr = 1'b1;
                if (!i_status.line_end) begin
                    o_cmd.line_step = 1'b1;
                    n_state         = S_LRD;
                end else if (i_status.seg_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.seg_next = 1'b1;
                    n_state        = S_LLOAD;
                end
            end
            S_CINIT: begin
                o_cmd.circ_init = 1'b1;
                n_state         = S_CRD;
            end
            S_CRD: begin
                o_cmd.use_circ = 1'b1;
                o_cmd.mem_rd   = 1'b1;
                n_state        = S_CWR;
            end
            S_CWR: begin
                o_cmd.use_circ = 1'b1;
                o_cmd.mem_wr   = 1'b1;
                if (i_status.r_zero) begin
                    n_state = S_FIN;
                end else if (!i_status.oct_last) begin
                    o_cmd.oct_next = 1'b1;
                    n_state        = S_CRD;
                end else if (i_status.circ_more) begin
                    o_cmd.circ_step = 1'b1;
                    n_state         = S_CRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RLOAD: begin
                o_cmd.line_load = 1'b1;
                n_state         = S_RRD;
            end
            S_RRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_RWT;
            end
            S_RWT: begin
                o_cmd.res_capture = 1'b1;
                n_state           = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_pixel = i_status.pixel;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pixel <= n_out_pixel;
    end

endmodule

/* rtl/shape_rasterizer_bitmap.sv */
// shape_rasterizer_bitmap: top level, stream ports, controller and datapath
// depends on srb_pkg, srb_ctrl, srb_datapath
//
// Draws into a one-bit canvas of CANVAS_WIDTH x CANVAS_HEIGHT pixels, one
// command per input beat: clear, line, rectangle outline, circle, triangle
// outline or pixel read; pixels off the canvas are clipped. Every command
// returns one output beat, the read pixel or zero. Commands run one at a
// time; the canvas is a row-wide single-port memory, so each plotted pixel
// costs a read and then a write of its row: a line adds a setup step per
// segment, a circle one setup step before its octant loop, a read loads,
// reads and captures, a clear does nothing beyond dispatch (row valid bits,
// no sweep), and every command also passes accept, dispatch and handoff.
// A finished result sits in an output register, so the next command is
// taken while it waits. No clearing pass follows reset.
module shape_rasterizer_bitmap
    import srb_pkg::*;
#(
    parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // func, x_a, y_a, x_b, y_b, x_c, y_c, rect_w, rect_h, radius, zero pad
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_on, zero pad
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

    t_item   item;
    t_cmd    cmd;
    t_status status;
    logic    out_pixel;

    // unpack the input beat, first field lowest
    always_comb begin
        item.func   = s_axis_tdata[2:0];
        item.x_a    = s_axis_tdata[9:3];
        item.y_a    = s_axis_tdata[14:10];
        item.x_b    = s_axis_tdata[21:15];
        item.y_b    = s_axis_tdata[26:22];
        item.x_c    = s_axis_tdata[33:27];
        item.y_c    = s_axis_tdata[38:34];
        item.rect_w = s_axis_tdata[45:39];
        item.rect_h = s_axis_tdata[50:46];
        item.radius = s_axis_tdata[57:51];
    end

    assign m_axis_tdata = {7'd0, out_pixel};

    srb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_pixel (out_pixel),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    srb_datapath #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

/* test/shape_rasterizer_bitmap_tb.sv */
// shape_rasterizer_bitmap_tb: self-checking bench for the shape rasterizer
// keeps its own canvas model and checks every output beat against it
// depends on srb_pkg and shape_rasterizer_bitmap
module shape_rasterizer_bitmap_tb;
    import srb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 80;
    localparam int CH = 25;
    localparam int CYCLE_LIMIT = 10000000;

    logic        i_clk;
    logic        i_rst_n;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;

    shape_rasterizer_bitmap u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    t_item      cmd_queue[$];
    logic [7:0] pixel_expect[$];
    bit         canvas[CH][CW];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         mismatches;
    int         cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // canvas model
    function automatic void plot(int x, int y);
        if (x >= 0 && x < CW && y >= 0 && y < CH) canvas[y][x] = 1'b1;
    endfunction

    function automatic void trace_segment(int x0, int y0, int x1, int y1);
        int dx, dy, sx, sy, err, e2;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;
        err = dx - dy;
        forever begin
            plot(x0, y0);
            if (x0 == x1 && y0 == y1) break;
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                x0 += sx;
            end
            if (e2 < dx) begin
                err += dx;
                y0 += sy;
            end
        end
    endfunction

    function automatic void plot_octants(int cx, int cy, int x, int y);
        plot(cx + x, cy + y); plot(cx - x, cy + y);
        plot(cx + x, cy - y); plot(cx - x, cy - y);
        plot(cx + y, cy + x); plot(cx - y, cy + x);
        plot(cx + y, cy - x); plot(cx - y, cy - x);
    endfunction

    function automatic void trace_ring(int cx, int cy, int r);
        int x, y, d;
        x = 0;
        y = r;
        d = CIRC_D_INIT - 2 * r;
        if (r == 0) begin
            plot(cx, cy);
            return;
        end
        plot_octants(cx, cy, x, y);
        while (y >= x) begin
            x++;
            if (d > 0) begin
                y--;
                d = d + 4 * (x - y) + CIRC_D_DIAG;
            end else begin
                d = d + 4 * x + CIRC_D_AXIS;
            end
            plot_octants(cx, cy, x, y);
        end
    endfunction

    // apply one command to the model and return the expected beat
    function automatic logic [7:0] rasterize(t_item c);
        int xa, ya, xb, yb, xc, yc, w, h, rad;
        logic [7:0] px;
        xa = int'(c.x_a); ya = int'(c.y_a); xb = int'(c.x_b); yb = int'(c.y_b);
        xc = int'(c.x_c); yc = int'(c.y_c); w = int'(c.rect_w); h = int'(c.rect_h);
        rad = int'(c.radius);
        px = '0;
        case (c.func)
            F_CLEAR: begin
                foreach (canvas[r, k]) canvas[r][k] = 1'b0;
            end
            F_LINE: trace_segment(xa, ya, xb, yb);
            F_RECT: begin
                if (w > 0 && h > 0) begin
                    trace_segment(xa, ya, xa + w - 1, ya);
                    trace_segment(xa, ya + h - 1, xa + w - 1, ya + h - 1);
                    trace_segment(xa, ya, xa, ya + h - 1);
                    trace_segment(xa + w - 1, ya, xa + w - 1, ya + h - 1);
                end
            end
            F_CIRC: trace_ring(xa, ya, rad);
            F_TRI: begin
                trace_segment(xa, ya, xb, yb);
                trace_segment(xb, yb, xc, yc);
                trace_segment(xc, yc, xa, ya);
            end
            F_READ: begin
                if (xa < CW && ya < CH) px[0] = canvas[ya][xa];
            end
            default: ;
        endcase
        return px;
    endfunction

    function automatic logic [63:0] pack_cmd(t_item c);
        return {6'd0, c.radius, c.rect_h, c.rect_w, c.y_c, c.x_c,
                c.y_b, c.x_b, c.y_a, c.x_a, c.func};
    endfunction

    function automatic t_item rand_cmd(int full_range);
        t_item c;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        c = raw[$bits(t_item)-1:0];
        if (full_range == 0) begin
            c.x_a = XF_W'($urandom_range(0, 79)); c.y_a = YF_W'($urandom_range(0, 24));
            c.x_b = XF_W'($urandom_range(0, 79)); c.y_b = YF_W'($urandom_range(0, 24));
            c.x_c = XF_W'($urandom_range(0, 79)); c.y_c = YF_W'($urandom_range(0, 24));
            c.rect_w = XF_W'($urandom_range(0, 30));
            c.rect_h = YF_W'($urandom_range(0, 12));
            c.radius = XF_W'($urandom_range(0, 15));
        end
        // mostly draws and reads, a few clears and unused codes
        case ($urandom_range(0, 19))
            0:        c.func = F_CLEAR;
            1:        c.func = FUNC_W'($urandom_range(6, 7));
            2, 3, 4:  c.func = F_LINE;
            5, 6:     c.func = F_RECT;
            7, 8:     c.func = F_CIRC;
            9, 10:    c.func = F_TRI;
            default:  c.func = F_READ;
        endcase
        return c;
    endfunction

    function automatic t_item mk(logic [2:0] f, int xa, int ya, int xb, int yb,
                                 int xc, int yc, int w, int h, int r);
        t_item c;
        c.func = f; c.x_a = XF_W'(xa); c.y_a = YF_W'(ya);
        c.x_b = XF_W'(xb); c.y_b = YF_W'(yb);
        c.x_c = XF_W'(xc); c.y_c = YF_W'(yc);
        c.rect_w = XF_W'(w); c.rect_h = YF_W'(h); c.radius = XF_W'(r);
        return c;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) pixel_expect.push_back(rasterize(cmd_queue.pop_front()));
            if (cmd_queue.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pack_cmd(cmd_queue[0]);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixel_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
                end else if (m_axis_tdata !== pixel_expect[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel_on mismatch: expected %h actual %h",
                                 pixel_expect[0], m_axis_tdata);
                    void'(pixel_expect.pop_front());
                end else begin
                    void'(pixel_expect.pop_front());
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("shape_rasterizer_bitmap_tb: done, errors");
            $finish;
        end
    end

    task automatic run_phase(int n, int idle, int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            // every fifth item probes the whole field range, clipping included
            cmd_queue.push_back(rand_cmd((i % 5) == 0));
            // follow draws with reads around the canvas
            if ($urandom_range(0, 2) == 0)
                cmd_queue.push_back(mk(F_READ, $urandom_range(0, 79),
                                       $urandom_range(0, 24), 0, 0, 0, 0, 0, 0, 0));
        end
        while (cmd_queue.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every command, zero sizes, clipping, unused codes
        cmd_queue.push_back(mk(F_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(F_LINE, 0, 0, 79, 24, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(F_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(F_READ, 79, 24, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(F_READ, 127, 31, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(F_RECT, 10, 5, 0, 0, 0, 0, 0, 6, 0));
        cmd_queue.push_back(mk(F_RECT, 10, 5, 0, 0, 0, 0, 6, 0, 0));
        cmd_queue.push_back(mk(F_RECT, 70, 20, 0, 0, 0, 0, 127, 31, 0));
        cmd_queue.push_back(mk(F_READ, 70, 24, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(F_CIRC, 40, 12, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(F_READ, 40, 12, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(F_CIRC, 2, 2, 0, 0, 0, 0, 0, 0, 127));
        cmd_queue.push_back(mk(F_CIRC, 40, 12, 0, 0, 0, 0, 0, 0, 10));
        cmd_queue.push_back(mk(F_TRI, 5, 20, 127, 0, 60, 31, 0, 0, 0));
        cmd_queue.push_back(mk(F_LINE, 127, 31, 100, 20, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(3'd6, 1, 1, 1, 1, 1, 1, 1, 1, 1));
        cmd_queue.push_back(mk(3'd7, 127, 31, 127, 31, 127, 31, 127, 31, 127));
        cmd_queue.push_back(mk(F_READ, 30, 12, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(F_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(F_READ, 40, 2, 0, 0, 0, 0, 0, 0, 0));
        while (cmd_queue.size() != 0) @(posedge i_clk);

        // random phases with the idling mixes
        run_phase(240, 0, 0);
        run_phase(180, 80, 0);
        run_phase(180, 0, 80);
        run_phase(120, 25, 25);

        while (pixel_expect.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pixel_expect.size() == 0)
            $display("shape_rasterizer_bitmap_tb: done, clean");
        else
            $display("shape_rasterizer_bitmap_tb: done, errors");
        $finish;
    end
endmodule

/* shape_rasterizer_bitmap.f */
rtl/srb_pkg.sv
rtl/srb_canvas.sv
rtl/srb_datapath.sv
rtl/srb_ctrl.sv
rtl/shape_rasterizer_bitmap.sv
test/shape_rasterizer_bitmap_tb.sv
